// ===== src/assert_macros.svh =====
// Assertion macros shared by the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while rst is high.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and silenced while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ght_pkg.sv =====
// Shared types, codes and widths of the generational handle table.
`timescale 1ns / 1ps
package ght_pkg;

  localparam int DEF_GRAPHICS_SLOTS = 64;
  localparam int DEF_USER_SLOTS     = 64;

  localparam int ACTION_W = 2;
  localparam int TYPE_W   = 4;
  localparam int SERIAL_W = 4;
  localparam int INDEX_W  = 16;
  localparam int HANDLE_W = 24;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADTYPE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STOCK   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SHARED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAPHICS_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAPHICS_HIGH = 2'd3;

  localparam logic [SERIAL_W-1:0] SER_STOCK  = 4'd0;
  localparam logic [SERIAL_W-1:0] SER_SHARED = 4'd1;
  localparam logic [SERIAL_W-1:0] SER_FIRST  = 4'd2;
  localparam logic [SERIAL_W-1:0] SER_LAST   = 4'd15;

  // One table entry as held in the slot RAM.
  typedef struct packed {
    logic                used;
    logic [SERIAL_W-1:0] serial;
    logic [TYPE_W-1:0]   kind;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

// ===== src/ght_if.sv =====
// Request, response and configuration channel interfaces of the handle table.
`timescale 1ns / 1ps
interface ght_req_if;
  import ght_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TYPE_W-1:0]   obj_type;
  logic                any_type;
  logic [HANDLE_W-1:0] handle_in;
  modport source(output valid, action, obj_type, any_type, handle_in, input ready);
  modport sink(input valid, action, obj_type, any_type, handle_in, output ready);
endinterface

interface ght_rsp_if;
  import ght_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic                in_user_table;
  logic [INDEX_W-1:0]  slot_index;
  modport source(output valid, status, handle_out, in_user_table, slot_index, input ready);
  modport sink(input valid, status, handle_out, in_user_table, slot_index, output ready);
endinterface

interface ght_cfg_if;
  import ght_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/generational_handle_table.sv =====
// Generational handle table with graphics and user slot tables, top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block holds two slot tables in RAM, one for graphics objects and one for
// user objects, and routes each request to a table by the object's type code.
// Register hands out the lowest free slot as a 24-bit handle (index, serial,
// type); unregister checks a handle, frees its slot and advances the serial
// from 15 round to 2; lookup checks a handle against an expected type or its
// own. One item is handled at a time, all through one sequencer that reads a
// slot, checks it and writes it back through the single port of each RAM.
// After reset a clearing pass writes every slot free with serial 2; items are
// not accepted during it, while configuration writes are. Each accepted item
// is first checked on its type and handle fields alone, and one that fails
// there goes straight to its result. Unregister and lookup then read the
// handle's slot and check it. Register searches for a free slot from slot 0:
// it reads one slot and checks it in the next cycle, until it finds a free
// slot or has examined the last slot of its table. The result moves into the
// output register once that register is free, i.e. empty or being collected,
// and the next item is taken as soon as the result sits in the output
// register, even if it has not been collected yet.
module generational_handle_table #(
  parameter int GRAPHICS_SLOTS = ght_pkg::DEF_GRAPHICS_SLOTS,
  parameter int USER_SLOTS     = ght_pkg::DEF_USER_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  ght_req_if.sink   req,
  ght_rsp_if.source rsp,
  ght_cfg_if.sink   cfg
);
  import ght_pkg::*;

  localparam int MAX_SLOTS = (GRAPHICS_SLOTS > USER_SLOTS) ? GRAPHICS_SLOTS : USER_SLOTS;
  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int GAW = $clog2(GRAPHICS_SLOTS);
  localparam int UAW = $clog2(USER_SLOTS);

  localparam logic [IW:0]        G_DEPTH  = (IW + 1)'(GRAPHICS_SLOTS);
  localparam logic [IW:0]        U_DEPTH  = (IW + 1)'(USER_SLOTS);
  localparam logic [IW-1:0]      G_LAST   = IW'(GRAPHICS_SLOTS - 1);
  localparam logic [IW-1:0]      U_LAST   = IW'(USER_SLOTS - 1);
  localparam logic [IW-1:0]      ALL_LAST = IW'(MAX_SLOTS - 1);
  localparam logic [INDEX_W-1:0] G_LIMIT  = INDEX_W'(GRAPHICS_SLOTS);
  localparam logic [INDEX_W-1:0] U_LIMIT  = INDEX_W'(USER_SLOTS);

  // Configuration registers.
  logic [TYPE_W-1:0] valid_low;
  logic [TYPE_W-1:0] valid_high;
  logic [TYPE_W-1:0] graphics_low;
  logic [TYPE_W-1:0] graphics_high;

  // Sequencer state and slot counter.
  state_t        state;
  state_t        state_next;
  logic [IW-1:0] idx;

  // The accepted item.
  logic [ACTION_W-1:0] q_action;
  logic [TYPE_W-1:0]   q_type;
  logic                q_any;
  logic [HANDLE_W-1:0] q_handle;
  logic                q_user;

  // Result waiting to be moved into the output register.
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_user;
  logic [INDEX_W-1:0]  res_slot;

  // Handle fields of the accepted item.
  logic [INDEX_W-1:0]  h_idx;
  logic [SERIAL_W-1:0] h_ser;
  logic [TYPE_W-1:0]   h_typ;

  logic                eval_fail;
  logic [STATUS_W-1:0] eval_status;
  logic                eval_user;

  slot_t g_rdata;
  slot_t u_rdata;
  slot_t rdata;
  slot_t wdata;
  logic  g_we;
  logic  u_we;
  logic  chk_we;
  logic  slot_free;
  logic  slot_hit;
  logic  slot_last;
  logic  out_free;
  logic  is_register;
  logic [SERIAL_W-1:0] serial_next;

  function automatic logic in_range(input logic [TYPE_W-1:0] t, input logic [TYPE_W-1:0] lo,
                                    input logic [TYPE_W-1:0] hi);
    in_range = (t >= lo) && (t <= hi);
  endfunction

  assign h_idx = q_handle[INDEX_W-1:0];
  assign h_ser = q_handle[INDEX_W +: SERIAL_W];
  assign h_typ = q_handle[INDEX_W + SERIAL_W +: TYPE_W];

  assign is_register = (q_action == ACT_REGISTER);
  assign out_free    = !rsp.valid || rsp.ready;
  assign cfg.ready   = 1'b1;

  // Checks that need only the item's own fields and the configuration.
  always_comb begin
    eval_fail   = 1'b0;
    eval_status = ST_OK;
    if (is_register) begin
      eval_user = !in_range(q_type, graphics_low, graphics_high);
      if (!in_range(q_type, valid_low, valid_high)) begin
        eval_fail   = 1'b1;
        eval_status = ST_BADTYPE;
      end
    end else begin
      eval_user = !in_range(h_typ, graphics_low, graphics_high);
      priority if (q_action == ACT_NONE || q_handle == '0) begin
        eval_fail   = 1'b1;
        eval_status = ST_STALE;
      end else if (q_action == ACT_LOOKUP && !q_any && q_type != h_typ) begin
        eval_fail   = 1'b1;
        eval_status = ST_BADTYPE;
      end else if (!in_range(h_typ, valid_low, valid_high)) begin
        eval_fail   = 1'b1;
        eval_status = ST_BADTYPE;
      end else if (h_ser == SER_STOCK) begin
        eval_fail   = 1'b1;
        eval_status = ST_STOCK;
      end else if (h_ser == SER_SHARED) begin
        eval_fail   = 1'b1;
        eval_status = ST_SHARED;
      end else if (eval_user ? (h_idx >= U_LIMIT) : (h_idx >= G_LIMIT)) begin
        eval_fail   = 1'b1;
        eval_status = ST_STALE;
      end else begin
        eval_fail   = 1'b0;
      end
    end
  end

  // Examination of the slot read back from the selected table.
  assign rdata       = q_user ? u_rdata : g_rdata;
  assign slot_free   = !rdata.used;
  assign slot_hit    = rdata.used && (rdata.serial == h_ser) && (rdata.kind == h_typ);
  assign slot_last   = (idx == (q_user ? U_LAST : G_LAST));
  assign serial_next = (rdata.serial >= SER_LAST) ? SER_FIRST : SERIAL_W'(rdata.serial + 1'b1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (idx == ALL_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = eval_fail ? S_DONE : S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (is_register && !slot_free && !slot_last) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and RAM writes.
  always_comb begin
    req.ready = 1'b0;
    chk_we    = 1'b0;
    g_we      = 1'b0;
    u_we      = 1'b0;
    wdata     = '{used: 1'b0, serial: SER_FIRST, kind: '0};
    unique case (state)
      S_CLEAR: begin
        g_we = ({1'b0, idx} < G_DEPTH);
        u_we = ({1'b0, idx} < U_DEPTH);
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_CHECK: begin
        if (is_register) begin
          chk_we = slot_free;
          wdata  = '{used: 1'b1, serial: rdata.serial, kind: q_type};
        end else begin
          chk_we = (q_action == ACT_UNREGISTER) && slot_hit;
          wdata  = '{used: 1'b0, serial: serial_next, kind: rdata.kind};
        end
        g_we = chk_we && !q_user;
        u_we = chk_we && q_user;
      end
      S_EVAL, S_READ, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  ght_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(GRAPHICS_SLOTS)
  ) u_graphics_ram (
    .clk  (clk),
    .we   (g_we),
    .addr (idx[GAW-1:0]),
    .wdata(wdata),
    .rdata(g_rdata)
  );

  ght_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(USER_SLOTS)
  ) u_user_ram (
    .clk  (clk),
    .we   (u_we),
    .addr (idx[UAW-1:0]),
    .wdata(wdata),
    .rdata(u_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      idx           <= '0;
      rsp.valid     <= 1'b0;
      valid_low     <= 4'd1;
      valid_high    <= 4'd15;
      graphics_low  <= 4'd1;
      graphics_high <= 4'd7;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_VALID_LOW:     valid_low     <= cfg.data;
          CFG_VALID_HIGH:    valid_high    <= cfg.data;
          CFG_GRAPHICS_LOW:  graphics_low  <= cfg.data;
          CFG_GRAPHICS_HIGH: graphics_high <= cfg.data;
          default:           valid_low     <= valid_low;
        endcase
      end

      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      // The counter sweeps every slot after reset, starts the free-slot
      // search at zero and otherwise points at the handle's slot.
      if (state == S_CLEAR) begin
        idx <= IW'(idx + 1'b1);
      end else if (state == S_EVAL) begin
        idx <= is_register ? '0 : h_idx[IW-1:0];
      end else if (state == S_CHECK && is_register && !slot_free && !slot_last) begin
        idx <= IW'(idx + 1'b1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      q_action <= req.action;
      q_type   <= req.obj_type;
      q_any    <= req.any_type;
      q_handle <= req.handle_in;
    end

    if (state == S_EVAL) begin
      q_user     <= eval_user;
      res_status <= eval_status;
      res_handle <= '0;
      res_user   <= 1'b0;
      res_slot   <= '0;
    end

    if (state == S_CHECK) begin
      if (is_register) begin
        if (slot_free) begin
          res_status <= ST_OK;
          res_handle <= {q_type, rdata.serial, INDEX_W'(idx)};
          res_user   <= q_user;
          res_slot   <= INDEX_W'(idx);
        end else begin
          // A full table is the one failure that names its table.
          res_status <= ST_FULL;
          res_handle <= '0;
          res_user   <= q_user;
          res_slot   <= '0;
        end
      end else if (slot_hit) begin
        res_status <= ST_OK;
        res_handle <= q_handle;
        res_user   <= q_user;
        res_slot   <= h_idx;
      end else begin
        res_status <= ST_STALE;
        res_handle <= '0;
        res_user   <= 1'b0;
        res_slot   <= '0;
      end
    end

    if (state == S_DONE && out_free) begin
      rsp.status        <= res_status;
      rsp.handle_out    <= res_handle;
      rsp.in_user_table <= res_user;
      rsp.slot_index    <= res_slot;
    end
  end

  // An accepted item closes the input until its result is out.
  `ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "item accepted while busy")

  // Outside the clearing pass at most one table is written per cycle.
  `ASSERT_IMPLIES(a_one_table, state != S_CLEAR, !(g_we && u_we), "both tables written")

  // A successful result always names a slot inside its table.
  `ASSERT_IMPLIES(a_slot_range, rsp.valid && rsp.status == ST_OK,
                  rsp.in_user_table ? (rsp.slot_index < U_LIMIT) : (rsp.slot_index < G_LIMIT),
                  "slot index beyond table")

endmodule

// ===== src/ght_ram.sv =====
// Single-port RAM with registered read, used for the slot tables.
`timescale 1ns / 1ps
module ght_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
